// ===== hdl/hfts_pkg.sv =====
`timescale 1ns / 1ps

package hfts_pkg;

  localparam int MAX_COLS_DEF = 256;
  localparam int MAX_ROWS_DEF = 256;
  localparam int QUEUE_DEPTH  = 4;
  localparam int STORE_DEPTH  = 65536;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 31;

  localparam logic [CFG_AW-1:0] CFG_GRID_COLS   = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_GRID_ROWS   = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_HALF_WIDTH  = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_HALF_DEPTH  = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_INV_SPACING = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_HEIGHT_STEP = 3'd5;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  typedef struct packed {
    logic               cmd;
    logic [15:0]        cell_index;
    logic [7:0]         height_byte;
    logic signed [31:0] x_pos;
    logic signed [31:0] z_pos;
  } in_item_t;

  typedef struct packed {
    logic [31:0] height;
    logic        outside;
  } out_item_t;

endpackage

// ===== hdl/hfts_ram.sv =====
`timescale 1ns / 1ps

module hfts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = hfts_pkg::STORE_DEPTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/hfts_fifo.sv =====
`timescale 1ns / 1ps

module hfts_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = hfts_pkg::QUEUE_DEPTH,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data,
  output logic [CW-1:0]    count
);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_pop;

  assign do_pop = pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_valid = (count_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];
  assign count     = count_r;

endmodule

// ===== hdl/hfts_front.sv =====
`timescale 1ns / 1ps

module hfts_front #(
  parameter int MAX_COLS = hfts_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = hfts_pkg::MAX_ROWS_DEF,
  parameter int DEPTH    = hfts_pkg::QUEUE_DEPTH,
  localparam int COL_W  = $clog2(MAX_COLS),
  localparam int ROW_W  = $clog2(MAX_ROWS),
  localparam int CDIM_W = $clog2(MAX_COLS + 1),
  localparam int RDIM_W = $clog2(MAX_ROWS + 1),
  localparam int CW     = $clog2(DEPTH + 1),
  localparam int QW     = 2 + COL_W + ROW_W + 56
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  hfts_pkg::in_item_t  in_data,
  input  logic [CDIM_W-1:0]   cols,
  input  logic [RDIM_W-1:0]   rows,
  input  logic [30:0]         half_width,
  input  logic [30:0]         half_depth,
  input  logic [23:0]         inv_spacing,
  input  logic [CW-1:0]       q_count,
  output logic                push,
  output logic [QW-1:0]       push_data
);

  logic        accept;
  logic        v1_r, cmd1_r;
  logic [15:0] idx1_r;
  logic [7:0]  byte1_r;
  logic [32:0] sx1_r, sx1_nxt;
  logic [32:0] sz1_r, sz1_nxt;

  logic        v2_r, cmd2_r;
  logic [15:0] idx2_r;
  logic [7:0]  byte2_r;
  logic        negx2_r, negx2_nxt;
  logic        negz2_r, negz2_nxt;
  logic [55:0] px2_r, px2_nxt;
  logic [55:0] pz2_r, pz2_nxt;
  logic [31:0] magx, magz;

  logic [23:0] colw, roww, cols_m1, rows_m1;
  logic        outside;

  // keep room in the queue for everything already in flight
  assign busy   = (32'(q_count) + 32'(v1_r) + 32'(v2_r)) >= 32'(DEPTH);
  assign accept = start && !busy;

  always_comb begin
    sx1_nxt = {in_data.x_pos[31], in_data.x_pos} + {2'b00, half_width};
    sz1_nxt = {2'b00, half_depth} - {in_data.z_pos[31], in_data.z_pos};
  end

  // a negative coordinate scaled by zero is zero, not negative
  always_comb begin
    magx      = sx1_r[32] ? 32'd0 : sx1_r[31:0];
    magz      = sz1_r[32] ? 32'd0 : sz1_r[31:0];
    negx2_nxt = sx1_r[32] && (inv_spacing != 24'd0);
    negz2_nxt = sz1_r[32] && (inv_spacing != 24'd0);
    px2_nxt   = {24'd0, magx} * {32'd0, inv_spacing};
    pz2_nxt   = {24'd0, magz} * {32'd0, inv_spacing};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    cmd1_r  <= in_data.cmd;
    idx1_r  <= in_data.cell_index;
    byte1_r <= in_data.height_byte;
    sx1_r   <= sx1_nxt;
    sz1_r   <= sz1_nxt;
    cmd2_r  <= cmd1_r;
    idx2_r  <= idx1_r;
    byte2_r <= byte1_r;
    negx2_r <= negx2_nxt;
    negz2_r <= negz2_nxt;
    px2_r   <= px2_nxt;
    pz2_r   <= pz2_nxt;
  end

  // far edge has no right or bottom corner
  always_comb begin
    colw    = px2_r[55:32];
    roww    = pz2_r[55:32];
    cols_m1 = 24'(cols) - 24'd1;
    rows_m1 = 24'(rows) - 24'd1;
    outside = negx2_r || negz2_r || (colw >= cols_m1) || (roww >= rows_m1);
  end

  assign push      = v2_r;
  assign push_data = {cmd2_r, outside, colw[COL_W-1:0], roww[ROW_W-1:0],
                      px2_r[31:16], pz2_r[31:16], idx2_r, byte2_r};

endmodule

// ===== hdl/hfts_back.sv =====
`timescale 1ns / 1ps

module hfts_back #(
  parameter int MAX_COLS = hfts_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = hfts_pkg::MAX_ROWS_DEF,
  localparam int COL_W  = $clog2(MAX_COLS),
  localparam int ROW_W  = $clog2(MAX_ROWS),
  localparam int CDIM_W = $clog2(MAX_COLS + 1),
  localparam int QW     = 2 + COL_W + ROW_W + 56
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pop_valid,
  input  logic [QW-1:0]       pop_data,
  output logic                pop,
  input  logic [CDIM_W-1:0]   cols,
  input  logic [23:0]         height_step,
  output logic                out_valid,
  output hfts_pkg::out_item_t out_data
);

  logic             p_cmd, p_out;
  logic [COL_W-1:0] p_col;
  logic [ROW_W-1:0] p_row;
  logic [15:0]      p_s, p_t, p_idx;
  logic [7:0]       p_byte;

  logic             b1_v_r, b1_cmd_r, b1_out_r;
  logic [COL_W-1:0] b1_col_r;
  logic [ROW_W-1:0] b1_row_r;
  logic [15:0]      b1_s_r, b1_t_r, b1_idx_r;
  logic [7:0]       b1_byte_r;
  logic [ROW_W+CDIM_W-1:0] row_base;

  logic             b2_v_r, b2_cmd_r, b2_out_r;
  logic [COL_W-1:0] b2_col_r;
  logic [15:0]      b2_s_r, b2_t_r, b2_idx_r, b2_base_r, b2_base_nxt;
  logic [7:0]       b2_byte_r;
  logic [15:0]      addr_a, addr_b, addr_c, addr_d;
  logic             wr_en;

  logic             q3_v_r, q3_out_r;
  logic [15:0]      q3_s_r, q3_t_r;
  logic [7:0]       ha, hb, hc, hd;

  logic                lower;
  logic signed [27:0]  base_h, hsum;
  logic signed [17:0]  w1, w2;
  logic signed [9:0]   d1, d2;
  logic                q4_v_r, q4_out_r;
  logic [23:0]         h4_r, h4_nxt;

  logic                q5_v_r, q5_out_r;
  logic [47:0]         prod5_r, prod5_nxt;

  logic                out_v_r;
  logic [31:0]         height_r;
  logic                outside_r;

  assign {p_cmd, p_out, p_col, p_row, p_s, p_t, p_idx, p_byte} = pop_data;
  assign pop = pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r  <= 1'b0;
      b2_v_r  <= 1'b0;
      q3_v_r  <= 1'b0;
      q4_v_r  <= 1'b0;
      q5_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      b1_v_r  <= pop_valid;
      b2_v_r  <= b1_v_r;
      q3_v_r  <= b2_v_r && (b2_cmd_r == hfts_pkg::CMD_QUERY);
      q4_v_r  <= q3_v_r;
      q5_v_r  <= q4_v_r;
      out_v_r <= q5_v_r;
    end
  end

  assign row_base    = b1_row_r * cols;
  assign b2_base_nxt = 16'(row_base);

  // corner addresses wrap around the store
  always_comb begin
    addr_a = b2_base_r + 16'(b2_col_r);
    addr_b = addr_a + 16'd1;
    addr_c = addr_a + 16'(cols);
    addr_d = addr_c + 16'd1;
    wr_en  = b2_v_r && (b2_cmd_r == hfts_pkg::CMD_LOAD);
  end

  hfts_ram #(.WIDTH(8), .DEPTH(hfts_pkg::STORE_DEPTH)) u_bank_a (
    .clk(clk), .we(wr_en), .waddr(b2_idx_r), .wdata(b2_byte_r),
    .raddr(addr_a), .rdata(ha)
  );
  hfts_ram #(.WIDTH(8), .DEPTH(hfts_pkg::STORE_DEPTH)) u_bank_b (
    .clk(clk), .we(wr_en), .waddr(b2_idx_r), .wdata(b2_byte_r),
    .raddr(addr_b), .rdata(hb)
  );
  hfts_ram #(.WIDTH(8), .DEPTH(hfts_pkg::STORE_DEPTH)) u_bank_c (
    .clk(clk), .we(wr_en), .waddr(b2_idx_r), .wdata(b2_byte_r),
    .raddr(addr_c), .rdata(hc)
  );
  hfts_ram #(.WIDTH(8), .DEPTH(hfts_pkg::STORE_DEPTH)) u_bank_d (
    .clk(clk), .we(wr_en), .waddr(b2_idx_r), .wdata(b2_byte_r),
    .raddr(addr_d), .rdata(hd)
  );

  // upper triangle A,B,C when s+t <= 1, else lower triangle D,C,B
  always_comb begin
    lower = ({1'b0, q3_s_r} + {1'b0, q3_t_r}) > hfts_pkg::ONE_Q16;
    if (!lower) begin
      base_h = $signed({4'd0, ha, 16'd0});
      w1     = $signed({2'b00, q3_s_r});
      d1     = $signed({2'b00, hb}) - $signed({2'b00, ha});
      w2     = $signed({2'b00, q3_t_r});
      d2     = $signed({2'b00, hc}) - $signed({2'b00, ha});
    end else begin
      base_h = $signed({4'd0, hd, 16'd0});
      w1     = $signed({1'b0, hfts_pkg::ONE_Q16 - {1'b0, q3_s_r}});
      d1     = $signed({2'b00, hc}) - $signed({2'b00, hd});
      w2     = $signed({1'b0, hfts_pkg::ONE_Q16 - {1'b0, q3_t_r}});
      d2     = $signed({2'b00, hb}) - $signed({2'b00, hd});
    end
    hsum   = base_h + w1 * d1 + w2 * d2;
    h4_nxt = hsum[27] ? 24'd0 : hsum[23:0];
  end

  assign prod5_nxt = {24'd0, h4_r} * {24'd0, height_step};

  always_ff @(posedge clk) begin
    b1_cmd_r  <= p_cmd;
    b1_out_r  <= p_out;
    b1_col_r  <= p_col;
    b1_row_r  <= p_row;
    b1_s_r    <= p_s;
    b1_t_r    <= p_t;
    b1_idx_r  <= p_idx;
    b1_byte_r <= p_byte;
    b2_cmd_r  <= b1_cmd_r;
    b2_out_r  <= b1_out_r;
    b2_col_r  <= b1_col_r;
    b2_s_r    <= b1_s_r;
    b2_t_r    <= b1_t_r;
    b2_idx_r  <= b1_idx_r;
    b2_byte_r <= b1_byte_r;
    b2_base_r <= b2_base_nxt;
    q3_out_r  <= b2_out_r;
    q3_s_r    <= b2_s_r;
    q3_t_r    <= b2_t_r;
    q4_out_r  <= q3_out_r;
    h4_r      <= h4_nxt;
    q5_out_r  <= q4_out_r;
    prod5_r   <= prod5_nxt;
    outside_r <= q5_out_r;
    height_r  <= q5_out_r ? 32'd0 : prod5_r[47:16];
  end

  assign out_valid        = out_v_r;
  assign out_data.height  = height_r;
  assign out_data.outside = outside_r;

endmodule

// ===== hdl/heightfield_triangle_height_sample_core.sv =====
`timescale 1ns / 1ps

// Terrain height sampler over a grid of raw 8-bit heights.
// Input: an item is taken on a clock edge with start high and busy low.
//   cmd load writes height_byte at cell_index; cmd query samples x_pos, z_pos.
// Output: each query gives one result, shown on out_data for a single cycle
//   with out_valid high; loads give none. The receiver cannot hold results off.
// Throughput: one item per cycle unless busy; loads and queries in any order.
//   The front computes cell coordinates in two stages, a 4-entry queue hands
//   them to the back, which reads four copies of the 64K x 8 height store
//   (one per triangle corner), then interpolates and scales.
// busy stays low in steady operation; it rises once queue and front hold 4 items.
// Configuration: cfg_we writes register cfg_addr with cfg_wdata;
//   write only while no item is in flight.
// Reset: registers return to their reset values and all in-flight items are
//   dropped. The height store is not cleared; load every cell before reading.
module heightfield_triangle_height_sample_core #(
  parameter int MAX_COLS = hfts_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = hfts_pkg::MAX_ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  hfts_pkg::in_item_t            in_data,
  output logic                          out_valid,
  output hfts_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  logic [hfts_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [hfts_pkg::CFG_DW-1:0]   cfg_wdata
);

  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int CDIM_W = $clog2(MAX_COLS + 1);
  localparam int RDIM_W = $clog2(MAX_ROWS + 1);
  localparam int CW     = $clog2(hfts_pkg::QUEUE_DEPTH + 1);
  localparam int QW     = 2 + COL_W + ROW_W + 56;

  logic [8:0]  grid_cols_r, grid_rows_r;
  logic [30:0] half_width_r, half_depth_r;
  logic [23:0] inv_spacing_r, height_step_r;

  logic [CDIM_W-1:0] cols_c;
  logic [RDIM_W-1:0] rows_c;

  logic          push, pop, pop_valid;
  logic [QW-1:0] push_data, pop_data;
  logic [CW-1:0] q_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r   <= 9'd2;
      grid_rows_r   <= 9'd2;
      half_width_r  <= 31'd0;
      half_depth_r  <= 31'd0;
      inv_spacing_r <= 24'd65536;
      height_step_r <= 24'd256;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        hfts_pkg::CFG_GRID_COLS:   grid_cols_r   <= cfg_wdata[8:0];
        hfts_pkg::CFG_GRID_ROWS:   grid_rows_r   <= cfg_wdata[8:0];
        hfts_pkg::CFG_HALF_WIDTH:  half_width_r  <= cfg_wdata;
        hfts_pkg::CFG_HALF_DEPTH:  half_depth_r  <= cfg_wdata;
        hfts_pkg::CFG_INV_SPACING: inv_spacing_r <= cfg_wdata[23:0];
        hfts_pkg::CFG_HEIGHT_STEP: height_step_r <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  // saturate the grid size into the supported range
  always_comb begin
    if (grid_cols_r < 9'd2) begin
      cols_c = CDIM_W'(2);
    end else if ({23'd0, grid_cols_r} > 32'(MAX_COLS)) begin
      cols_c = CDIM_W'(MAX_COLS);
    end else begin
      cols_c = CDIM_W'(grid_cols_r);
    end
    if (grid_rows_r < 9'd2) begin
      rows_c = RDIM_W'(2);
    end else if ({23'd0, grid_rows_r} > 32'(MAX_ROWS)) begin
      rows_c = RDIM_W'(MAX_ROWS);
    end else begin
      rows_c = RDIM_W'(grid_rows_r);
    end
  end

  hfts_front #(
    .MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS), .DEPTH(hfts_pkg::QUEUE_DEPTH)
  ) u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .cols(cols_c), .rows(rows_c), .half_width(half_width_r),
    .half_depth(half_depth_r), .inv_spacing(inv_spacing_r),
    .q_count(q_count), .push(push), .push_data(push_data)
  );

  hfts_fifo #(.WIDTH(QW), .DEPTH(hfts_pkg::QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data),
    .pop(pop), .pop_valid(pop_valid), .pop_data(pop_data), .count(q_count)
  );

  hfts_back #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_back (
    .clk(clk), .rst_n(rst_n), .pop_valid(pop_valid), .pop_data(pop_data),
    .pop(pop), .cols(cols_c), .height_step(height_step_r),
    .out_valid(out_valid), .out_data(out_data)
  );

  a_query_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.cmd == hfts_pkg::CMD_QUERY)) |-> ##9 out_valid)
    else $error("query result missing after fixed latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy && (in_data.cmd == hfts_pkg::CMD_QUERY)) |-> ##9 !out_valid)
    else $error("result without a matching query");

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.outside) |-> (out_data.height == 32'd0))
    else $error("outside result carries a height");

  a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("queue backed up");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import hfts_pkg::*;

  localparam int SETTLE_CYCLES = 12;
  localparam int STALL_LIMIT   = 5000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;

  heightfield_triangle_height_sample_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // shadow copy of the block state
  logic [7:0]  terrain_mem [0:STORE_DEPTH-1];
  logic [8:0]  sh_cols, sh_rows;
  logic [30:0] sh_half_w, sh_half_d;
  logic [23:0] sh_inv_sp, sh_step;

  in_item_t  pending_items[$];
  out_item_t expected_heights[$];
  int        mismatches;
  int        gap_left;
  logic      took;
  logic      quiet_mode;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int clamp_dim(input logic [8:0] v);
    if (v < 2) return 2;
    if (v > 256) return 256;
    return int'(v);
  endfunction

  function automatic void predict_height(input in_item_t it);
    longint    x, z, pc, pd, c, d, colw, roww, s, t, h, ca, cb, cc, cd, scaled;
    int        cols, rows;
    logic [15:0] a0;
    out_item_t r;
    if (it.cmd == CMD_LOAD) begin
      terrain_mem[it.cell_index] = it.height_byte;
      return;
    end
    cols = clamp_dim(sh_cols);
    rows = clamp_dim(sh_rows);
    x = longint'(it.x_pos);
    z = longint'(it.z_pos);
    pc = (x + longint'(sh_half_w)) * longint'(sh_inv_sp);
    pd = (longint'(sh_half_d) - z) * longint'(sh_inv_sp);
    r.height = '0;
    r.outside = 1'b1;
    if (pc >= 0 && pd >= 0) begin
      c = pc >> 16;
      d = pd >> 16;
      colw = c >> 16;
      roww = d >> 16;
      if (colw < cols - 1 && roww < rows - 1) begin
        s = c & 64'hFFFF;
        t = d & 64'hFFFF;
        a0 = 16'(roww * cols + colw);
        ca = longint'(terrain_mem[a0]);
        cb = longint'(terrain_mem[16'(a0 + 1)]);
        cc = longint'(terrain_mem[16'(a0 + cols)]);
        cd = longint'(terrain_mem[16'(a0 + cols + 1)]);
        if (s + t <= 65536) h = ca * 65536 + s * (cb - ca) + t * (cc - ca);
        else h = cd * 65536 + (65536 - s) * (cc - cd) + (65536 - t) * (cb - cd);
        if (h < 0) h = 0;
        scaled = (h * longint'(sh_step)) >> 16;
        if (scaled > 64'hFFFFFFFF) scaled = 64'hFFFFFFFF;
        r.height = scaled[31:0];
        r.outside = 1'b0;
      end
    end
    expected_heights.push_back(r);
  endfunction

  // input side: accept on rising edge, predict immediately
  always @(posedge clk) begin
    took <= rst_n && start && !busy;
    if (rst_n && start && !busy) predict_height(in_data);
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (start && !took) begin
      start <= 1'b1;
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_items.size() > 0) begin
      in_data <= pending_items.pop_front();
      start <= 1'b1;
      if (quiet_mode) gap_left <= 0;
      else if ($urandom_range(0, 9) == 0) gap_left <= int'($urandom_range(5, 30));
      else gap_left <= int'($urandom_range(0, 2));
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid) begin
      if (expected_heights.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result height=%h outside=%b",
                   out_data.height, out_data.outside);
      end else begin
        e = expected_heights.pop_front();
        if (e.height !== out_data.height || e.outside !== out_data.outside) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: height exp %h got %h, outside exp %b got %b",
                     e.height, out_data.height, e.outside, out_data.outside);
        end
      end
    end
  end

  // stop if nothing moves for too long
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((start && !busy) || out_valid) idle = 0;
      else idle++;
      if (idle >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_GRID_COLS:   sh_cols = val[8:0];
      CFG_GRID_ROWS:   sh_rows = val[8:0];
      CFG_HALF_WIDTH:  sh_half_w = val[30:0];
      CFG_HALF_DEPTH:  sh_half_d = val[30:0];
      CFG_INV_SPACING: sh_inv_sp = val[23:0];
      CFG_HEIGHT_STEP: sh_step = val[23:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    wait (pending_items.size() == 0 && gap_left == 0 && !start &&
          expected_heights.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic push_load(input logic [15:0] idx, input logic [7:0] hb);
    in_item_t it;
    it = '0;
    it.cmd = CMD_LOAD;
    it.cell_index = idx;
    it.height_byte = hb;
    it.x_pos = $urandom;
    it.z_pos = $urandom;
    pending_items.push_back(it);
  endtask

  task automatic push_query(input logic [31:0] x, input logic [31:0] z);
    in_item_t it;
    it.cmd = CMD_QUERY;
    it.cell_index = 16'($urandom);
    it.height_byte = 8'($urandom);
    it.x_pos = x;
    it.z_pos = z;
    pending_items.push_back(it);
  endtask

  task automatic load_cells(input int first, input int n);
    for (int i = 0; i < n; i++) push_load(16'(first + i), 8'($urandom));
  endtask

  // fill every cell of the current grid so no query reads an unloaded entry
  task automatic load_grid();
    load_cells(0, clamp_dim(sh_cols) * clamp_dim(sh_rows));
  endtask

  // aimed queries cover columns 0 to span, plus the corners right of them
  task automatic random_traffic(input int n, input int span);
    longint tc, td, x, z;
    int cols, rows;
    cols = clamp_dim(sh_cols);
    rows = clamp_dim(sh_rows);
    for (int i = 0; i < n; i++) begin
      quiet_mode = ($urandom_range(0, 7) == 0);
      case ($urandom_range(0, 9))
        0: push_load(16'($urandom), 8'($urandom));
        1: push_load(16'($urandom_range(0, cols * rows - 1)), 8'($urandom));
        2: push_query($urandom, $urandom);
        default: begin
          // aim inside the grid, a little past the far edge now and then
          tc = longint'($urandom_range(0, span * 65536 + 65535));
          td = longint'($urandom_range(0, rows * 65536 + 65535));
          if (sh_inv_sp == 0) begin
            x = longint'($urandom);
            z = longint'($urandom);
          end else begin
            x = (tc << 16) / sh_inv_sp - sh_half_w + $urandom_range(0, 1);
            z = sh_half_d - (td << 16) / sh_inv_sp - $urandom_range(0, 1);
          end
          push_query(x[31:0], z[31:0]);
        end
      endcase
      if (pending_items.size() > 20) wait (pending_items.size() < 8);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    mismatches = 0;
    quiet_mode = 1'b0;
    sh_cols = 9'd2;
    sh_rows = 9'd2;
    sh_half_w = 31'd0;
    sh_half_d = 31'd0;
    sh_inv_sp = 24'd65536;
    sh_step = 24'd256;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: corners, both triangles, points before and past the grid
    load_grid();
    push_load(16'hFFFF, 8'hFF);
    push_load(16'h0000, 8'h00);
    push_load(16'h0001, 8'hFF);
    push_load(16'h0002, 8'h80);
    push_load(16'h0003, 8'h01);
    push_query(32'd0, 32'd0);
    push_query(32'h0000_8000, -32'sh0000_8000);
    push_query(32'h0000_C000, -32'sh0000_C000);
    push_query(32'h0000_FFFF, -32'sh0000_FFFF);
    push_query(32'h0000_FFFF, 32'd0);
    push_query(32'd0, -32'sh0000_FFFF);
    push_query(-32'sd1, 32'd0);
    push_query(32'd0, 32'd1);
    push_query(32'h0001_0000, 32'd0);
    push_query(32'd0, -32'sh0001_0000);
    push_query(32'h7FFF_FFFF, 32'h8000_0000);
    push_query(32'h8000_0000, 32'h7FFF_FFFF);
    push_query(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_traffic(70, 2);
    drain();

    write_reg(CFG_GRID_COLS, 31'd5);
    write_reg(CFG_GRID_ROWS, 31'd4);
    write_reg(CFG_HALF_WIDTH, 31'h0002_8000);
    write_reg(CFG_HALF_DEPTH, 31'h0002_0000);
    write_reg(CFG_INV_SPACING, 31'd65536);
    write_reg(CFG_HEIGHT_STEP, 31'hFF_FFFF);
    @(negedge clk) cfg_we <= 1'b0;
    load_grid();
    random_traffic(90, 5);
    drain();

    // oversized column count, undersized row count, widest coordinate span
    write_reg(CFG_GRID_COLS, 31'd511);
    write_reg(CFG_GRID_ROWS, 31'd0);
    write_reg(CFG_HALF_WIDTH, 31'h7FFF_FFFF);
    write_reg(CFG_HALF_DEPTH, 31'd0);
    write_reg(CFG_INV_SPACING, 31'hFF_FFFF);
    write_reg(CFG_HEIGHT_STEP, 31'd0);
    @(negedge clk) cfg_we <= 1'b0;
    // aim at the first few columns only and load both rows there
    load_cells(0, 10);
    load_cells(256, 10);
    random_traffic(70, 6);
    drain();

    write_reg(CFG_GRID_COLS, 31'd2);
    write_reg(CFG_GRID_ROWS, 31'd256);
    write_reg(CFG_HALF_WIDTH, 31'd0);
    write_reg(CFG_HALF_DEPTH, 31'h7FFF_FFFF);
    write_reg(CFG_INV_SPACING, 31'd1);
    write_reg(CFG_HEIGHT_STEP, 31'd65536);
    @(negedge clk) cfg_we <= 1'b0;
    // with the smallest nonzero inverse spacing only the first cell can be inside
    load_cells(0, 4);
    random_traffic(70, 2);
    drain();

    write_reg(CFG_GRID_COLS, 31'd8);
    write_reg(CFG_GRID_ROWS, 31'd6);
    write_reg(CFG_HALF_WIDTH, 31'h0004_0000);
    write_reg(CFG_HALF_DEPTH, 31'h0003_0000);
    write_reg(CFG_INV_SPACING, 31'h02_0000);
    write_reg(CFG_HEIGHT_STEP, 31'd1000);
    @(negedge clk) cfg_we <= 1'b0;
    load_grid();
    random_traffic(90, 8);
    drain();

    // degenerate spacing: every point collapses onto the first cell
    write_reg(CFG_INV_SPACING, 31'd0);
    write_reg(CFG_HEIGHT_STEP, 31'd256);
    @(negedge clk) cfg_we <= 1'b0;
    random_traffic(50, 8);
    drain();

    if (mismatches == 0 && expected_heights.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
